>>> src/frir_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// frir_pkg
// Shared types, codes and helpers for the framed image receiver.
// ----------------------------------------------------------------------------
package frir_pkg;

    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] ALL_ONES = 32'hFFFFFFFF;

    // Magic sequence, one character per matched position
    localparam logic [7:0] MAGIC_0 = 8'h4C;
    localparam logic [7:0] MAGIC_1 = 8'h4B;
    localparam logic [7:0] MAGIC_2 = 8'h42;
    localparam logic [7:0] MAGIC_3 = 8'h54;

    // Configuration register indexes
    localparam logic [1:0] CFG_MAX_SIZE   = 2'd0;
    localparam logic [1:0] CFG_PROMPT_PER = 2'd1;
    localparam logic [1:0] CFG_HDR_TMO    = 2'd2;
    localparam logic [1:0] CFG_PAY_TMO    = 2'd3;

    localparam logic [31:0] MAX_SIZE_RST   = 32'd33521664;
    localparam logic [31:0] PROMPT_PER_RST = 32'd54000000;
    localparam logic [31:0] HDR_TMO_RST    = 32'd54000000;
    localparam logic [31:0] PAY_TMO_RST    = 32'd108000000;

    // Phase codes
    localparam logic [1:0] PH_HUNT    = 2'd0;
    localparam logic [1:0] PH_HEADER  = 2'd1;
    localparam logic [1:0] PH_PAYLOAD = 2'd2;

    // Status codes
    localparam logic [2:0] ST_NONE        = 3'd0;
    localparam logic [2:0] ST_PROMPT      = 3'd1;
    localparam logic [2:0] ST_HEADER_OK   = 3'd2;
    localparam logic [2:0] ST_SIZE_ERR    = 3'd3;
    localparam logic [2:0] ST_HDR_TIMEOUT = 3'd4;
    localparam logic [2:0] ST_PAY_TIMEOUT = 3'd5;
    localparam logic [2:0] ST_CRC_BAD     = 3'd6;
    localparam logic [2:0] ST_CRC_OK      = 3'd7;

    localparam int QUEUE_DEPTH = 2;

    // Classified item as it travels from front to back
    typedef struct packed {
        logic       is_tick;
        logic [7:0] data;
        logic [3:0] magic_eq;   // data equals magic character i
    } item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        wr_valid;
        logic [31:0] wr_offset;
        logic [7:0]  wr_data;
        logic [31:0] crc_result;
        logic [31:0] bytes_received;
    } result_t;

    typedef struct packed {
        logic [31:0] max_size;
        logic [31:0] prompt_period;
        logic [31:0] hdr_timeout;
        logic [31:0] pay_timeout;
    } cfg_t;

    function automatic logic [31:0] crc_fold(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == ALL_ONES) ? v : v + 32'd1;
    endfunction

endpackage
`default_nettype wire

>>> src/frir_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// frir_front
// Input side: takes items while the queue has room and classifies them.
// ----------------------------------------------------------------------------
module frir_front (
    input  wire logic          in_valid,
    input  wire logic          cmd,
    input  wire logic [7:0]    rx_byte,
    output logic               in_stall,
    input  wire logic          q_full,
    output logic               push,
    output frir_pkg::item_t    push_item
);
    import frir_pkg::*;

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    // Precompute the magic compares so the back engine only selects
    always_comb
    begin
        push_item.is_tick     = cmd;
        push_item.data        = rx_byte;
        push_item.magic_eq[0] = (rx_byte == MAGIC_0);
        push_item.magic_eq[1] = (rx_byte == MAGIC_1);
        push_item.magic_eq[2] = (rx_byte == MAGIC_2);
        push_item.magic_eq[3] = (rx_byte == MAGIC_3);
    end

endmodule
`default_nettype wire

>>> src/frir_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// frir_queue
// Two-entry queue of classified items between front and back.
// ----------------------------------------------------------------------------
module frir_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire frir_pkg::item_t push_item,
    output logic               q_full,
    output logic               q_valid,
    input  wire logic          pop,
    output frir_pkg::item_t    pop_item
);
    import frir_pkg::*;

    item_t      mem_reg [QUEUE_DEPTH];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign q_full   = (count_reg == 2'(QUEUE_DEPTH));
    assign q_valid  = (count_reg != 2'd0);
    assign pop_item = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

>>> src/frir_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// frir_back
// Protocol engine: hunt, header, payload with CRC, plus config registers
// and the output register.
// ----------------------------------------------------------------------------
module frir_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            q_valid,
    input  wire frir_pkg::item_t pop_item,
    output logic                 pop,
    input  wire logic            cfg_valid,
    input  wire logic [1:0]      cfg_index,
    input  wire logic [31:0]     cfg_data,
    output logic                 out_valid,
    input  wire logic            out_stall,
    output frir_pkg::result_t    out_result
);
    import frir_pkg::*;

    cfg_t        cfg_reg;
    logic [1:0]  phase_reg,    phase_next;
    logic [1:0]  matched_reg,  matched_next;
    logic [2:0]  hdr_idx_reg,  hdr_idx_next;
    logic [31:0] size_reg,     size_next;
    logic [31:0] exp_crc_reg,  exp_crc_next;
    logic [31:0] crc_reg,      crc_next;
    logic [31:0] count_reg,    count_next;
    logic [31:0] idle_reg,     idle_next;
    logic [31:0] prompt_reg,   prompt_next;
    logic        out_valid_reg, out_valid_next;
    result_t     out_reg;
    result_t     res;

    logic [31:0] idle_inc;
    logic [31:0] prompt_inc;
    logic [31:0] crc_fold_val;
    logic [31:0] count_inc;
    logic [31:0] crc_final;
    logic        magic_hit;

    assign pop        = q_valid && (!out_valid_reg || !out_stall);
    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;

    assign idle_inc     = sat_inc(idle_reg);
    assign prompt_inc   = sat_inc(prompt_reg);
    assign crc_fold_val = crc_fold(crc_reg, pop_item.data);
    assign count_inc    = count_reg + 32'd1;
    assign crc_final    = ~crc_fold_val;
    assign magic_hit    = pop_item.magic_eq[matched_reg];

    always_comb
    begin
        phase_next   = phase_reg;
        matched_next = matched_reg;
        hdr_idx_next = hdr_idx_reg;
        size_next    = size_reg;
        exp_crc_next = exp_crc_reg;
        crc_next     = crc_reg;
        count_next   = count_reg;
        idle_next    = idle_reg;
        prompt_next  = prompt_reg;
        res          = '0;

        case (phase_reg)
            PH_HEADER:
            begin
                if (pop_item.is_tick)
                begin
                    idle_next = idle_inc;
                    if (idle_inc > cfg_reg.hdr_timeout)
                    begin
                        res.status   = ST_HDR_TIMEOUT;
                        phase_next   = PH_HUNT;
                        matched_next = 2'd0;
                        prompt_next  = ALL_ONES;
                    end
                end
                else
                begin
                    if (!hdr_idx_reg[2])
                    begin
                        size_next[8*hdr_idx_reg[1:0] +: 8] = pop_item.data;
                    end
                    else
                    begin
                        exp_crc_next[8*hdr_idx_reg[1:0] +: 8] = pop_item.data;
                    end
                    idle_next    = 32'd0;
                    hdr_idx_next = hdr_idx_reg + 3'd1;
                    if (hdr_idx_reg == 3'd7)
                    begin
                        // size bytes are all in; the last byte went to the CRC
                        if (size_reg == 32'd0 || size_reg > cfg_reg.max_size)
                        begin
                            res.status   = ST_SIZE_ERR;
                            phase_next   = PH_HUNT;
                            matched_next = 2'd0;
                            prompt_next  = ALL_ONES;
                        end
                        else
                        begin
                            res.status = ST_HEADER_OK;
                            phase_next = PH_PAYLOAD;
                            crc_next   = ALL_ONES;
                            count_next = 32'd0;
                        end
                    end
                end
            end

            PH_PAYLOAD:
            begin
                if (pop_item.is_tick)
                begin
                    idle_next = idle_inc;
                    if (idle_inc > cfg_reg.pay_timeout)
                    begin
                        res.status         = ST_PAY_TIMEOUT;
                        res.bytes_received = count_reg;
                        phase_next         = PH_HUNT;
                        matched_next       = 2'd0;
                        prompt_next        = ALL_ONES;
                    end
                end
                else
                begin
                    res.wr_valid       = 1'b1;
                    res.wr_offset      = count_reg;
                    res.wr_data        = pop_item.data;
                    res.bytes_received = count_inc;
                    crc_next           = crc_fold_val;
                    count_next         = count_inc;
                    idle_next          = 32'd0;
                    if (count_inc >= size_reg)
                    begin
                        res.crc_result = crc_final;
                        res.status     = (crc_final == exp_crc_reg) ? ST_CRC_OK : ST_CRC_BAD;
                        phase_next     = PH_HUNT;
                        matched_next   = 2'd0;
                        prompt_next    = ALL_ONES;
                    end
                end
            end

            default:
            begin
                // hunting; the unused phase code behaves the same
                if (pop_item.is_tick)
                begin
                    prompt_next = prompt_inc;
                    if (matched_reg == 2'd0 && prompt_inc >= cfg_reg.prompt_period)
                    begin
                        res.status  = ST_PROMPT;
                        prompt_next = 32'd0;
                    end
                end
                else if (magic_hit)
                begin
                    if (matched_reg == 2'd3)
                    begin
                        matched_next = 2'd0;
                        phase_next   = PH_HEADER;
                        hdr_idx_next = 3'd0;
                        size_next    = 32'd0;
                        exp_crc_next = 32'd0;
                        idle_next    = 32'd0;
                    end
                    else
                    begin
                        matched_next = matched_reg + 2'd1;
                    end
                end
                else
                begin
                    // restart, keeping the byte if it opens the sequence
                    matched_next = {1'b0, pop_item.magic_eq[0]};
                end
            end
        endcase
    end

    always_comb
    begin
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_reg <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_size      <= MAX_SIZE_RST;
            cfg_reg.prompt_period <= PROMPT_PER_RST;
            cfg_reg.hdr_timeout   <= HDR_TMO_RST;
            cfg_reg.pay_timeout   <= PAY_TMO_RST;
            phase_reg     <= PH_HUNT;
            matched_reg   <= 2'd0;
            hdr_idx_reg   <= 3'd0;
            size_reg      <= 32'd0;
            exp_crc_reg   <= 32'd0;
            crc_reg       <= ALL_ONES;
            count_reg     <= 32'd0;
            idle_reg      <= 32'd0;
            prompt_reg    <= ALL_ONES;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_MAX_SIZE:   cfg_reg.max_size      <= cfg_data;
                    CFG_PROMPT_PER: cfg_reg.prompt_period <= cfg_data;
                    CFG_HDR_TMO:    cfg_reg.hdr_timeout   <= cfg_data;
                    CFG_PAY_TMO:    cfg_reg.pay_timeout   <= cfg_data;
                    default:        cfg_reg.max_size      <= cfg_reg.max_size;
                endcase
            end
            if (pop)
            begin
                phase_reg   <= phase_next;
                matched_reg <= matched_next;
                hdr_idx_reg <= hdr_idx_next;
                size_reg    <= size_next;
                exp_crc_reg <= exp_crc_next;
                crc_reg     <= crc_next;
                count_reg   <= count_next;
                idle_reg    <= idle_next;
                prompt_reg  <= prompt_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTH
    a_match_only_hunting: assert property (@(posedge clk) disable iff (!rst_n)
        matched_reg != 2'd0 |-> (phase_reg != PH_HEADER && phase_reg != PH_PAYLOAD))
        else $error("magic match count held outside hunt phase");

    a_count_below_size: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAYLOAD |-> count_reg < size_reg)
        else $error("payload count reached declared size without leaving payload");

    a_write_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.wr_valid |->
            (out_reg.status == ST_NONE || out_reg.status == ST_CRC_OK
             || out_reg.status == ST_CRC_BAD))
        else $error("payload write carries a non-payload status");

    a_crc_status_has_write: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_reg.status == ST_CRC_OK || out_reg.status == ST_CRC_BAD)
            |-> out_reg.wr_valid)
        else $error("CRC verdict without the final payload write");
`endif

endmodule
`default_nettype wire

>>> src/framed_image_receiver_crc32.sv
`default_nettype none
// ----------------------------------------------------------------------------
// framed_image_receiver_crc32
// Framed image receiver: magic hunt, header, payload writes and CRC-32 check.
// ----------------------------------------------------------------------------
// The block takes one item per clock unless in_stall is high, a received
// byte or a timer tick, and gives exactly one result for each. Sustained
// rate is one item per cycle while the output is not stalled; an item
// passes through the item queue, then the output register. The back
// engine folds one byte into the reflected CRC-32 and updates its
// counters for each item it pops. Configuration writes are always accepted
// (cfg_ready is tied high) and must only be made while the block is idle.
// No clearing pass follows reset.
// ----------------------------------------------------------------------------
module framed_image_receiver_crc32 (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // item channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        cmd,
    input  wire logic [7:0]  rx_byte,
    // result channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       status,
    output logic             wr_valid,
    output logic [31:0]      wr_offset,
    output logic [7:0]       wr_data,
    output logic [31:0]      crc_result,
    output logic [31:0]      bytes_received,
    // configuration write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    import frir_pkg::*;

    logic    q_full;
    logic    q_valid;
    logic    push;
    logic    pop;
    item_t   push_item;
    item_t   pop_item;
    result_t result;

    // Config registers take a transfer in any cycle
    assign cfg_ready = 1'b1;

    // Front: hold off the source only when the queue is full
    frir_front u_front (
        .in_valid  (in_valid),
        .cmd       (cmd),
        .rx_byte   (rx_byte),
        .in_stall  (in_stall),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item)
    );

    // Queue: decouple input acceptance from output backpressure
    frir_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .q_full    (q_full),
        .q_valid   (q_valid),
        .pop       (pop),
        .pop_item  (pop_item)
    );

    // Back: advance the protocol state and load the output register
    frir_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .pop_item   (pop_item),
        .pop        (pop),
        .cfg_valid  (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_result (result)
    );

    // Split the result register onto its field ports
    assign status         = result.status;
    assign wr_valid       = result.wr_valid;
    assign wr_offset      = result.wr_offset;
    assign wr_data        = result.wr_data;
    assign crc_result     = result.crc_result;
    assign bytes_received = result.bytes_received;

endmodule
`default_nettype wire

>>> verif/frir_result_checker.sv
// ----------------------------------------------------------------------------
// frir_result_checker
// Watches the item, result and configuration channels of the framed image
// receiver, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module frir_result_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        cmd,
    input  logic [7:0]  rx_byte,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [2:0]  status,
    input  logic        wr_valid,
    input  logic [31:0] wr_offset,
    input  logic [7:0]  wr_data,
    input  logic [31:0] crc_result,
    input  logic [31:0] bytes_received,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          fail_count,
    output int          n_pending
);
    import frir_pkg::*;

    cfg_t        regs;
    logic [1:0]  phase;
    logic [2:0]  magic_cnt;
    logic [2:0]  hdr_idx;
    logic [31:0] size_field;
    logic [31:0] crc_field;
    logic [31:0] crc_run;
    logic [31:0] rx_count;
    logic [31:0] idle_cnt;
    logic [31:0] prompt_cnt;
    result_t     reply_q[$];
    result_t     got;
    result_t     want;

    initial begin
        fail_count = 0;
        n_pending  = 0;
    end

    function automatic logic [31:0] bump(input logic [31:0] v);
        return (v == ALL_ONES) ? v : v + 32'd1;
    endfunction

    task automatic report_error(input string msg);
        $display("[%0t] checker: %s", $time, msg);
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] seen,
                               input logic [31:0] exp);
        if (seen !== exp)
            report_error($sformatf("%s is 0x%08h, predicted 0x%08h", name, seen, exp));
    endtask

    task automatic rehunt();
        phase      = PH_HUNT;
        magic_cnt  = '0;
        prompt_cnt = ALL_ONES;
    endtask

    // Advance the receiver state by one item and queue the reply it causes
    task automatic predict_reply(input logic is_tick, input logic [7:0] b);
        result_t     r;
        logic [7:0]  char_due;
        logic [31:0] c;
        r = '0;
        if (phase == PH_HEADER) begin
            if (is_tick) begin
                idle_cnt = bump(idle_cnt);
                if (idle_cnt > regs.hdr_timeout) begin
                    r.status = ST_HDR_TIMEOUT;
                    rehunt();
                end
            end
            else begin
                if (hdr_idx < 3'd4)
                    size_field[8*hdr_idx[1:0] +: 8] = b;
                else
                    crc_field[8*hdr_idx[1:0] +: 8] = b;
                idle_cnt = '0;
                if (hdr_idx == 3'd7) begin
                    hdr_idx = '0;
                    if (size_field == '0 || size_field > regs.max_size) begin
                        r.status = ST_SIZE_ERR;
                        rehunt();
                    end
                    else begin
                        r.status = ST_HEADER_OK;
                        phase    = PH_PAYLOAD;
                        crc_run  = ALL_ONES;
                        rx_count = '0;
                    end
                end
                else begin
                    hdr_idx = hdr_idx + 3'd1;
                end
            end
        end
        else if (phase == PH_PAYLOAD) begin
            if (is_tick) begin
                idle_cnt = bump(idle_cnt);
                if (idle_cnt > regs.pay_timeout) begin
                    r.status         = ST_PAY_TIMEOUT;
                    r.bytes_received = rx_count;
                    rehunt();
                end
            end
            else begin
                r.wr_valid  = 1'b1;
                r.wr_offset = rx_count;
                r.wr_data   = b;
                // bit-serial reflected CRC-32, LSB of the byte first
                c = crc_run;
                for (int i = 0; i < 8; i++) begin
                    if (c[0] ^ b[i])
                        c = {1'b0, c[31:1]} ^ CRC_POLY;
                    else
                        c = {1'b0, c[31:1]};
                end
                crc_run          = c;
                rx_count         = rx_count + 32'd1;
                idle_cnt         = '0;
                r.bytes_received = rx_count;
                if (rx_count >= size_field) begin
                    r.crc_result = ~crc_run;
                    r.status     = (~crc_run == crc_field) ? ST_CRC_OK : ST_CRC_BAD;
                    rehunt();
                end
            end
        end
        else begin
            if (is_tick) begin
                prompt_cnt = bump(prompt_cnt);
                if (magic_cnt == '0 && prompt_cnt >= regs.prompt_period) begin
                    r.status   = ST_PROMPT;
                    prompt_cnt = '0;
                end
            end
            else begin
                case (magic_cnt[1:0])
                    2'd0:    char_due = MAGIC_0;
                    2'd1:    char_due = MAGIC_1;
                    2'd2:    char_due = MAGIC_2;
                    default: char_due = MAGIC_3;
                endcase
                if (b == char_due) begin
                    if (magic_cnt[1:0] == 2'd3) begin
                        magic_cnt  = '0;
                        phase      = PH_HEADER;
                        hdr_idx    = '0;
                        size_field = '0;
                        crc_field  = '0;
                        idle_cnt   = '0;
                    end
                    else begin
                        magic_cnt = {1'b0, magic_cnt[1:0]} + 3'd1;
                    end
                end
                else begin
                    magic_cnt = (b == MAGIC_0) ? 3'd1 : 3'd0;
                end
            end
        end
        reply_q.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            regs.max_size      = MAX_SIZE_RST;
            regs.prompt_period = PROMPT_PER_RST;
            regs.hdr_timeout   = HDR_TMO_RST;
            regs.pay_timeout   = PAY_TMO_RST;
            phase      = PH_HUNT;
            magic_cnt  = '0;
            hdr_idx    = '0;
            size_field = '0;
            crc_field  = '0;
            crc_run    = ALL_ONES;
            rx_count   = '0;
            idle_cnt   = '0;
            prompt_cnt = ALL_ONES;
            reply_q.delete();
            n_pending  = 0;
        end
        else begin
            if (out_valid && !out_stall) begin
                got = '{status, wr_valid, wr_offset, wr_data, crc_result, bytes_received};
                if (reply_q.size() == 0) begin
                    report_error($sformatf("result with nothing outstanding, status %0d",
                                           status));
                end
                else begin
                    want = reply_q.pop_front();
                    check_field("status", 32'(got.status), 32'(want.status));
                    check_field("wr_valid", 32'(got.wr_valid), 32'(want.wr_valid));
                    check_field("wr_offset", got.wr_offset, want.wr_offset);
                    check_field("wr_data", 32'(got.wr_data), 32'(want.wr_data));
                    check_field("crc_result", got.crc_result, want.crc_result);
                    check_field("bytes_received", got.bytes_received, want.bytes_received);
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_MAX_SIZE:   regs.max_size      = cfg_data;
                    CFG_PROMPT_PER: regs.prompt_period = cfg_data;
                    CFG_HDR_TMO:    regs.hdr_timeout   = cfg_data;
                    default:        regs.pay_timeout   = cfg_data;
                endcase
            end
            if (in_valid && !in_stall)
                predict_reply(cmd, rx_byte);
            n_pending = reply_q.size();
        end
    end

endmodule

>>> verif/framed_image_receiver_crc32_tb.sv
// ----------------------------------------------------------------------------
// framed_image_receiver_crc32_tb
// Drives framed images, noise and timer ticks into the receiver under several
// register settings and idle patterns; a checker beside the block predicts
// and compares every result, and this top gives the verdict.
// ----------------------------------------------------------------------------
module framed_image_receiver_crc32_tb;
    import frir_pkg::*;

    // Item kinds on the cmd port
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Cycles without any transfer before the run is declared hung
    localparam int QUIET_LIMIT = 4000;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        cmd       = 1'b0;
    logic [7:0]  rx_byte   = '0;
    logic        out_stall = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [1:0]  cfg_index = CFG_MAX_SIZE;
    logic [31:0] cfg_data  = '0;

    logic        in_stall;
    logic        out_valid;
    logic [2:0]  status;
    logic        wr_valid;
    logic [31:0] wr_offset;
    logic [7:0]  wr_data;
    logic [31:0] crc_result;
    logic [31:0] bytes_received;
    logic        cfg_ready;

    int          fail_count;
    int          n_pending;
    int          n_items      = 0;
    int          quiet_cycles = 0;
    int          send_gap_pct = 0;
    int          stall_pct    = 0;
    int          tick_pct     = 0;
    logic [31:0] cur_max      = MAX_SIZE_RST;

    framed_image_receiver_crc32 u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .cmd            (cmd),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .wr_valid       (wr_valid),
        .wr_offset      (wr_offset),
        .wr_data        (wr_data),
        .crc_result     (crc_result),
        .bytes_received (bytes_received),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    frir_result_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .cmd            (cmd),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .wr_valid       (wr_valid),
        .wr_offset      (wr_offset),
        .wr_data        (wr_data),
        .crc_result     (crc_result),
        .bytes_received (bytes_received),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .n_pending      (n_pending)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Receiver back-pressure: re-roll the stall at every falling edge
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Hang detection: count cycles with no transfer on any channel
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Offer one item and hold it until the transfer happens. Valid stays
    // high on return so back-to-back items never toggle it within a step.
    task automatic push_item(input logic kind, input logic [7:0] value);
        @(negedge clk);
        while ($urandom_range(99) < send_gap_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= kind;
        rx_byte  <= value;
        do
            @(posedge clk);
        while (in_stall);
        n_items++;
    endtask

    // Ticks carry a random byte to show that rx_byte is ignored for them
    task automatic tick_burst(input int count);
        repeat (count) push_item(CMD_TICK, 8'($urandom_range(255)));
    endtask

    task automatic gap_ticks();
        if ($urandom_range(99) < tick_pct)
            tick_burst($urandom_range(1, 6));
    endtask

    // Drop valid and hold off until every predicted result has come back
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (n_pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Write all four registers; only call while the block is idle
    task automatic set_config(input logic [31:0] max_size, input logic [31:0] prompt,
                              input logic [31:0] hdr_tmo, input logic [31:0] pay_tmo);
        logic [31:0] vals [4];
        logic [1:0]  idx  [4];
        vals = '{max_size, prompt, hdr_tmo, pay_tmo};
        idx  = '{CFG_MAX_SIZE, CFG_PROMPT_PER, CFG_HDR_TMO, CFG_PAY_TMO};
        for (int i = 0; i < 4; i++) begin
            @(negedge clk);
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= vals[i];
            do
                @(posedge clk);
            while (!cfg_ready);
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
        cur_max = max_size;
    endtask

    // Magic, n_hdr header bytes (size then CRC, little endian), n_pay payload
    // bytes; ticks fall between bytes at the current tick rate
    task automatic send_frame(input logic [31:0] size, input bit corrupt,
                              input int n_hdr, input int n_pay);
        logic [7:0]  magic [4];
        logic [7:0]  pay   [$];
        logic [31:0] crc;
        logic [63:0] hdr;
        magic = '{MAGIC_0, MAGIC_1, MAGIC_2, MAGIC_3};
        for (int i = 0; i < n_pay; i++) pay.push_back(8'($urandom_range(255)));
        crc = ALL_ONES;
        foreach (pay[i]) begin
            crc = crc ^ {24'd0, pay[i]};
            repeat (8) crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
        end
        crc = ~crc;
        if (corrupt) crc = crc ^ ($urandom | 32'd1);
        hdr = {crc, size};
        foreach (magic[i]) begin
            push_item(CMD_BYTE, magic[i]);
            gap_ticks();
        end
        for (int i = 0; i < n_hdr; i++) begin
            push_item(CMD_BYTE, hdr[8*i +: 8]);
            gap_ticks();
        end
        foreach (pay[i]) begin
            push_item(CMD_BYTE, pay[i]);
            if (i + 1 < n_pay) gap_ticks();
        end
    endtask

    // Stray bytes, ticks and fragments of the magic
    task automatic noise();
        repeat ($urandom_range(1, 8)) begin
            case ($urandom_range(3))
                0: push_item(CMD_TICK, 8'($urandom_range(255)));
                1: push_item(CMD_BYTE, 8'($urandom_range(255)));
                2: push_item(CMD_BYTE, MAGIC_0);
                default: push_item(CMD_BYTE, ($urandom_range(1) != 0) ? MAGIC_1 : MAGIC_2);
            endcase
        end
    endtask

    // Mostly well-formed frames with random content, plus broken frames and
    // noise, until the item count reaches goal; optionally drain once midway
    task automatic random_traffic(input int goal, input int pause_at);
        logic [31:0] size;
        logic [31:0] lim;
        int          roll;
        int          n_hdr;
        int          n_pay;
        bit          size_ok;
        while (n_items < goal) begin
            if ($urandom_range(99) < 15) begin
                noise();
            end
            else begin
                lim  = (cur_max < 32'd20) ? cur_max : 32'd20;
                roll = $urandom_range(99);
                if (roll < 8)
                    size = '0;
                else if (roll < 16 && cur_max <= 32'd64)
                    size = (roll < 12) ? cur_max + 32'd1 : $urandom;
                else if (roll < 22)
                    size = lim;
                else
                    size = $urandom_range(1, lim);
                size_ok = (size != '0) && (size <= cur_max);
                n_hdr   = 8;
                n_pay   = size_ok ? int'(size) : 0;
                roll    = $urandom_range(99);
                if (roll < 7) begin
                    n_hdr = $urandom_range(0, 7);
                    n_pay = 0;
                end
                else if (roll < 14 && size_ok) begin
                    n_pay = $urandom_range(0, int'(size) - 1);
                end
                send_frame(size, $urandom_range(99) < 20, n_hdr, n_pay);
                // let a cut-short frame run into its timeout
                if (n_hdr < 8 || (size_ok && n_pay < int'(size)))
                    tick_burst($urandom_range(1, 8));
            end
            if (pause_at > 0 && n_items >= pause_at) begin
                drain();
                pause_at = 0;
            end
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_gap_pct = 21;
        stall_pct    = 58;

        // With reset registers the first tick prompts at once, the next does not
        tick_burst(2);
        drain();
        set_config(32'd8, 32'd2, 32'd2, 32'd3);

        // A doubled leading magic byte restarts the hunt at one, then a
        // one-byte frame with a good CRC (last write carries the verdict)
        push_item(CMD_BYTE, MAGIC_0);
        send_frame(32'd1, 1'b0, 8, 1);
        // Header stalls after two bytes until ticks exceed the timeout
        send_frame(32'd1, 1'b0, 2, 0);
        tick_burst(3);
        drain();

        // Lowest prompt period, short timeouts
        tick_pct = 25;
        set_config(32'd16, 32'd1, 32'd3, 32'd4);
        random_traffic(300, 0);
        drain();

        // Swap idle rates; all-ones registers: timeouts never fire
        send_gap_pct = 58;
        stall_pct    = 21;
        set_config(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
        random_traffic(560, 0);
        drain();

        // No idling; smallest size limit, header timeout on the first tick
        send_gap_pct = 0;
        stall_pct    = 0;
        tick_pct     = 5;
        set_config(32'd1, 32'd5, 32'd0, 32'd1);
        random_traffic(800, 0);
        drain();

        // Mid-range settings with one full drain partway through
        tick_pct = 20;
        set_config(32'd12, 32'd4, 32'd5, 32'd6);
        random_traffic(1050, 920);

        drain();
        repeat (20) @(negedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> files.f
src/frir_pkg.sv
src/frir_front.sv
src/frir_queue.sv
src/frir_back.sv
src/framed_image_receiver_crc32.sv
verif/frir_result_checker.sv
verif/framed_image_receiver_crc32_tb.sv
